/* hw/rtl/ccrp_pkg.sv */
// ----------------------------------------------------------------------------
// ccrp_pkg
// Shared types, codes and schema tables for the certificate record parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ccrp_pkg;

  localparam int unsigned MAX_ID_LEN_DEFAULT = 64;
  localparam int unsigned KEY_LEN            = 33;
  localparam int unsigned ARRAY_COUNT        = 8;
  localparam int unsigned QUEUE_DEPTH        = 4;
  localparam int unsigned QUEUE_AW           = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CW           = $clog2(QUEUE_DEPTH + 1);

  localparam logic [4:0] INFO_MASK   = 5'h1F;
  localparam logic [4:0] INFO_ONE    = 5'd24;
  localparam logic [4:0] INFO_EIGHT  = 5'd27;

  typedef enum logic [3:0] {
    STEP_ARRAY      = 4'd0,
    STEP_TYPE       = 4'd1,
    STEP_SERIAL     = 4'd2,
    STEP_SUBJ_HEAD  = 4'd3,
    STEP_SUBJ_BYTES = 4'd4,
    STEP_ISS_HEAD   = 4'd5,
    STEP_ISS_BYTES  = 4'd6,
    STEP_START      = 4'd7,
    STEP_DURATION   = 4'd8,
    STEP_USAGE      = 4'd9,
    STEP_KEY_HEAD   = 4'd10,
    STEP_KEY_BYTES  = 4'd11
  } step_t;

  typedef enum logic [1:0] {
    KIND_NUMERIC = 2'd0,
    KIND_STRING  = 2'd1,
    KIND_DONE    = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_MAJOR     = 3'd1,
    ERR_COUNT     = 3'd2,
    ERR_RESERVED  = 3'd3,
    ERR_TRUNCATED = 3'd4,
    ERR_ID_LEN    = 3'd5,
    ERR_KEY_LEN   = 3'd6
  } err_t;

  localparam logic [2:0] MAJOR_UINT  = 3'd0;
  localparam logic [2:0] MAJOR_BYTES = 3'd2;
  localparam logic [2:0] MAJOR_ARRAY = 3'd4;
  localparam logic [2:0] MAJOR_OTHER = 3'd7;

  // One request as it leaves the front: an optional field or string result
  // followed by an optional completion or error result.
  typedef struct packed {
    logic        has_a;
    logic        a_string;
    logic [2:0]  a_field;
    logic [63:0] a_value;
    logic [7:0]  a_index;
    logic        has_b;
    logic        b_done;
    err_t        b_err;
  } entry_t;

  function automatic logic [2:0] major_for_step(input step_t step);
    case (step)
      STEP_ARRAY:                                 major_for_step = MAJOR_ARRAY;
      STEP_TYPE, STEP_SERIAL, STEP_START,
      STEP_DURATION, STEP_USAGE:                  major_for_step = MAJOR_UINT;
      STEP_SUBJ_HEAD, STEP_SUBJ_BYTES, STEP_ISS_HEAD,
      STEP_ISS_BYTES, STEP_KEY_HEAD, STEP_KEY_BYTES: major_for_step = MAJOR_BYTES;
      default:                                    major_for_step = MAJOR_OTHER;
    endcase
  endfunction

  function automatic logic [2:0] step_field(input step_t step);
    case (step)
      STEP_ARRAY, STEP_TYPE:          step_field = 3'd0;
      STEP_SERIAL:                    step_field = 3'd1;
      STEP_SUBJ_HEAD, STEP_SUBJ_BYTES: step_field = 3'd2;
      STEP_ISS_HEAD, STEP_ISS_BYTES:  step_field = 3'd3;
      STEP_START:                     step_field = 3'd4;
      STEP_DURATION:                  step_field = 3'd5;
      STEP_USAGE:                     step_field = 3'd6;
      STEP_KEY_HEAD, STEP_KEY_BYTES:  step_field = 3'd7;
      default:                        step_field = 3'd0;
    endcase
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/ccrp_front.sv */
// ----------------------------------------------------------------------------
// ccrp_front
// Byte-wise schema parser: tracks the record position, decodes CBOR heads
// and pushes one request per byte that yields results.
// ----------------------------------------------------------------------------
`default_nettype none

module ccrp_front #(
  parameter int unsigned MAX_ID_LEN = ccrp_pkg::MAX_ID_LEN_DEFAULT
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            accept,
  input  wire logic [7:0]      data_byte,
  input  wire logic            frame_last,
  output ccrp_pkg::entry_t     entry,
  output logic                 push
);

  ccrp_pkg::step_t step, step_next;
  logic [3:0]  head_left, head_left_next;
  logic [63:0] accum, accum_next;
  logic [7:0]  str_left, str_left_next, str_dec;
  logic [7:0]  str_pos, str_pos_next;
  logic        skip, skip_next;

  logic        have;
  logic [63:0] value;
  logic        done;
  ccrp_pkg::err_t err;
  logic [2:0]  major;
  logic [4:0]  info;

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= ccrp_pkg::STEP_ARRAY;
      head_left <= '0;
      accum     <= '0;
      str_left  <= '0;
      str_pos   <= '0;
      skip      <= 1'b0;
    end else if (accept) begin
      step      <= step_next;
      head_left <= head_left_next;
      accum     <= accum_next;
      str_left  <= str_left_next;
      str_pos   <= str_pos_next;
      skip      <= skip_next;
    end
  end

  assign major   = data_byte[7:5];
  assign info    = data_byte[4:0] & ccrp_pkg::INFO_MASK;
  assign str_dec = (str_left != 8'd0) ? str_left - 8'd1 : 8'd0;

  always_comb begin
    step_next      = step;
    head_left_next = head_left;
    accum_next     = accum;
    str_left_next  = str_left;
    str_pos_next   = str_pos;
    skip_next      = skip;
    entry          = '0;
    entry.b_err    = ccrp_pkg::ERR_NONE;
    have           = 1'b0;
    value          = '0;
    done           = 1'b0;
    err            = ccrp_pkg::ERR_NONE;

    if (skip) begin
      if (frame_last) begin
        step_next      = ccrp_pkg::STEP_ARRAY;
        head_left_next = '0;
        accum_next     = '0;
        str_left_next  = '0;
        str_pos_next   = '0;
        skip_next      = 1'b0;
      end
    end else begin
      if (step == ccrp_pkg::STEP_SUBJ_BYTES || step == ccrp_pkg::STEP_ISS_BYTES ||
          step == ccrp_pkg::STEP_KEY_BYTES) begin
        entry.has_a    = 1'b1;
        entry.a_string = 1'b1;
        entry.a_field  = ccrp_pkg::step_field(step);
        entry.a_value  = {56'd0, data_byte};
        entry.a_index  = str_pos;
        str_pos_next   = str_pos + 8'd1;
        str_left_next  = str_dec;
        if (str_dec == 8'd0) begin
          if (step == ccrp_pkg::STEP_KEY_BYTES) begin
            done = 1'b1;
          end else begin
            step_next = ccrp_pkg::step_t'(step + 4'd1);
          end
        end
      end else begin
        if (head_left != 4'd0) begin
          accum_next     = {accum[55:0], data_byte};
          head_left_next = head_left - 4'd1;
          if (head_left == 4'd1) begin
            have  = 1'b1;
            value = {accum[55:0], data_byte};
          end
        end else if (major != ccrp_pkg::major_for_step(step)) begin
          err = ccrp_pkg::ERR_MAJOR;
        end else if (info < ccrp_pkg::INFO_ONE) begin
          have  = 1'b1;
          value = {59'd0, info};
        end else if (info <= ccrp_pkg::INFO_EIGHT) begin
          head_left_next = 4'd1 << info[1:0];
          accum_next     = '0;
        end else begin
          err = ccrp_pkg::ERR_RESERVED;
        end

        if (have) begin
          case (step)
            ccrp_pkg::STEP_ARRAY: begin
              if (value != 64'(ccrp_pkg::ARRAY_COUNT)) begin
                err = ccrp_pkg::ERR_COUNT;
              end else begin
                step_next = ccrp_pkg::STEP_TYPE;
              end
            end
            ccrp_pkg::STEP_TYPE, ccrp_pkg::STEP_USAGE: begin
              entry.has_a   = 1'b1;
              entry.a_field = ccrp_pkg::step_field(step);
              entry.a_value = {56'd0, value[7:0]};
              step_next     = ccrp_pkg::step_t'(step + 4'd1);
            end
            ccrp_pkg::STEP_SERIAL, ccrp_pkg::STEP_START, ccrp_pkg::STEP_DURATION: begin
              entry.has_a   = 1'b1;
              entry.a_field = ccrp_pkg::step_field(step);
              entry.a_value = value;
              step_next     = ccrp_pkg::step_t'(step + 4'd1);
            end
            ccrp_pkg::STEP_SUBJ_HEAD, ccrp_pkg::STEP_ISS_HEAD: begin
              if (value > 64'(MAX_ID_LEN)) begin
                err = ccrp_pkg::ERR_ID_LEN;
              end else if (value == 64'd0) begin
                step_next = ccrp_pkg::step_t'(step + 4'd2);
              end else begin
                str_left_next = value[7:0];
                str_pos_next  = '0;
                step_next     = ccrp_pkg::step_t'(step + 4'd1);
              end
            end
            ccrp_pkg::STEP_KEY_HEAD: begin
              if (value != 64'(ccrp_pkg::KEY_LEN)) begin
                err = ccrp_pkg::ERR_KEY_LEN;
              end else begin
                str_left_next = value[7:0];
                str_pos_next  = '0;
                step_next     = ccrp_pkg::STEP_KEY_BYTES;
              end
            end
            default: begin
              err = ccrp_pkg::ERR_MAJOR;
            end
          endcase
        end
      end

      if (!done && err == ccrp_pkg::ERR_NONE && frame_last) begin
        err = ccrp_pkg::ERR_TRUNCATED;
      end
      if (err != ccrp_pkg::ERR_NONE) begin
        entry.has_b = 1'b1;
        entry.b_err = err;
      end else if (done) begin
        entry.has_b  = 1'b1;
        entry.b_done = 1'b1;
      end

      if (err != ccrp_pkg::ERR_NONE || done) begin
        if (frame_last) begin
          step_next      = ccrp_pkg::STEP_ARRAY;
          head_left_next = '0;
          accum_next     = '0;
          str_left_next  = '0;
          str_pos_next   = '0;
          skip_next      = 1'b0;
        end else begin
          skip_next = 1'b1;
        end
      end
    end
  end

  assign push = accept && (entry.has_a || entry.has_b);

endmodule

`default_nettype wire

/* hw/rtl/ccrp_queue.sv */
// ----------------------------------------------------------------------------
// ccrp_queue
// Short request queue between the parser front and the result back.
// ----------------------------------------------------------------------------
`default_nettype none

module ccrp_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire ccrp_pkg::entry_t  push_entry,
  input  wire logic              pop,
  output ccrp_pkg::entry_t       head,
  output logic                   full,
  output logic                   empty
);

  ccrp_pkg::entry_t slots [ccrp_pkg::QUEUE_DEPTH];
  logic [ccrp_pkg::QUEUE_AW-1:0] wr_ptr, rd_ptr;
  logic [ccrp_pkg::QUEUE_CW-1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == ccrp_pkg::QUEUE_AW'(ccrp_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == ccrp_pkg::QUEUE_AW'(ccrp_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign head  = slots[rd_ptr];
  assign full  = (count == ccrp_pkg::QUEUE_CW'(ccrp_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);

endmodule

`default_nettype wire

/* hw/rtl/ccrp_back.sv */
// ----------------------------------------------------------------------------
// ccrp_back
// Result sequencer: splits each request into one or two result items and
// holds them in the output register until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module ccrp_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ccrp_pkg::entry_t  head,
  input  wire logic              empty,
  output logic                   pop,
  output logic                   item_valid,
  input  wire logic              item_stall,
  output logic [1:0]             item_kind,
  output logic [2:0]             field_id,
  output logic [63:0]            field_value,
  output logic [7:0]             string_index,
  output logic [2:0]             error_code,
  output logic                   run_last
);

  logic             load;
  logic             pend_b;
  logic             pend_done;
  ccrp_pkg::err_t   pend_err;

  assign load = !item_valid || !item_stall;
  assign pop  = load && !pend_b && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      pend_b     <= 1'b0;
    end else if (load) begin
      if (pend_b) begin
        item_valid <= 1'b1;
        pend_b     <= 1'b0;
      end else if (!empty) begin
        item_valid <= 1'b1;
        pend_b     <= head.has_a && head.has_b;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (pend_b) begin
        item_kind    <= pend_done ? ccrp_pkg::KIND_DONE : ccrp_pkg::KIND_ERROR;
        field_id     <= '0;
        field_value  <= '0;
        string_index <= '0;
        error_code   <= pend_err;
        run_last     <= 1'b1;
      end else if (!empty) begin
        pend_done <= head.b_done;
        pend_err  <= head.b_err;
        if (head.has_a) begin
          item_kind    <= head.a_string ? ccrp_pkg::KIND_STRING : ccrp_pkg::KIND_NUMERIC;
          field_id     <= head.a_field;
          field_value  <= head.a_value;
          string_index <= head.a_index;
          error_code   <= ccrp_pkg::ERR_NONE;
          run_last     <= !head.has_b;
        end else begin
          item_kind    <= head.b_done ? ccrp_pkg::KIND_DONE : ccrp_pkg::KIND_ERROR;
          field_id     <= '0;
          field_value  <= '0;
          string_index <= '0;
          error_code   <= head.b_err;
          run_last     <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/cbor_cert_record_parser_core.sv */
// ----------------------------------------------------------------------------
// cbor_cert_record_parser_core
// Fixed-schema CBOR certificate record parser, one input byte per request.
//
//   channel  valid       stall       payload
//   bytes    byte_valid  byte_stall  data_byte, frame_last
//   items    item_valid  item_stall  item_kind, field_id, field_value,
//                                    string_index, error_code, run_last
//
// Input bytes are taken one per cycle while the request queue has room.
// A byte yields zero, one or two items; the back emits one item per cycle
// while item_stall is low, and a byte with two items gives the field or
// string item first. A byte is written to a queue slot, then the output register.
// Reset is synchronous and needs no sweep; the core takes bytes right after.
// byte_stall rises only when the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module cbor_cert_record_parser_core #(
  parameter int unsigned MAX_ID_LEN = ccrp_pkg::MAX_ID_LEN_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        byte_valid,
  output logic             byte_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        frame_last,
  output logic             item_valid,
  input  wire logic        item_stall,
  output logic [1:0]       item_kind,
  output logic [2:0]       field_id,
  output logic [63:0]      field_value,
  output logic [7:0]       string_index,
  output logic [2:0]       error_code,
  output logic             run_last
);

  logic             accept;
  logic             push;
  logic             pop;
  logic             full;
  logic             empty;
  ccrp_pkg::entry_t push_entry;
  ccrp_pkg::entry_t head;

  assign byte_stall = full;
  assign accept     = byte_valid && !full;

  ccrp_front #(
    .MAX_ID_LEN (MAX_ID_LEN)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .data_byte  (data_byte),
    .frame_last (frame_last),
    .entry      (push_entry),
    .push       (push)
  );

  ccrp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .full       (full),
    .empty      (empty)
  );

  ccrp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .empty        (empty),
    .pop          (pop),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item_kind    (item_kind),
    .field_id     (field_id),
    .field_value  (field_value),
    .string_index (string_index),
    .error_code   (error_code),
    .run_last     (run_last)
  );

endmodule

`default_nettype wire
